>>> sv/imc_pkg.sv
`default_nettype none
package imc_pkg;

  localparam int unsigned CfgW = 16;
  localparam int unsigned IdxW = 3;

  localparam logic [IdxW-1:0] REG_STILL_ACCEL = 3'd0;
  localparam logic [IdxW-1:0] REG_STILL_GYRO  = 3'd1;
  localparam logic [IdxW-1:0] REG_SHAKE_ACCEL = 3'd2;
  localparam logic [IdxW-1:0] REG_SHAKE_GYRO  = 3'd3;
  localparam logic [IdxW-1:0] REG_CONFIRM     = 3'd4;
  localparam logic [IdxW-1:0] REG_HOLD_MS     = 3'd5;
  localparam logic [IdxW-1:0] REG_GAIN        = 3'd6;

  localparam logic [1:0] ACT_STILL  = 2'd0;
  localparam logic [1:0] ACT_MOVING = 2'd1;
  localparam logic [1:0] ACT_SHAKE  = 2'd2;

  localparam logic [15:0] ONE_G = 16'd4096;
  localparam logic signed [25:0] HALF_TURN = 26'sd11796480;
  localparam logic signed [25:0] ANGLE_LIMIT = 26'sd46080;
  localparam logic [8:0] GAIN_MAX = 9'd256;

  typedef struct packed {
    logic       load;
    logic       step;
    logic [3:0] iter;
  } imc_ctl_t;

  function automatic logic signed [25:0] atan_tab(input logic [3:0] i);
    logic signed [25:0] r;
    unique case (i)
      4'd0:  r = 26'sd2949120;
      4'd1:  r = 26'sd1740967;
      4'd2:  r = 26'sd919879;
      4'd3:  r = 26'sd466945;
      4'd4:  r = 26'sd234379;
      4'd5:  r = 26'sd117304;
      4'd6:  r = 26'sd58666;
      4'd7:  r = 26'sd29335;
      4'd8:  r = 26'sd14668;
      4'd9:  r = 26'sd7334;
      4'd10: r = 26'sd3667;
      4'd11: r = 26'sd1833;
      4'd12: r = 26'sd917;
      4'd13: r = 26'sd458;
      4'd14: r = 26'sd229;
      default: r = 26'sd115;
    endcase
    return r;
  endfunction

  function automatic logic signed [16:0] lp_filter(input logic signed [16:0] level,
                                                   input logic signed [16:0] raw,
                                                   input logic [8:0] gain);
    logic [8:0] g;
    logic signed [17:0] diff;
    logic signed [27:0] prod;
    logic signed [27:0] adj;
    g = (gain > GAIN_MAX) ? GAIN_MAX : gain;
    diff = {raw[16], raw} - {level[16], level};
    prod = $signed({1'b0, g}) * diff;
    adj = (prod + 28'sd128) >>> 8;
    return level + adj[16:0];
  endfunction

endpackage
`default_nettype wire

>>> sv/imc_isqrt.sv
`default_nettype none
module imc_isqrt import imc_pkg::*; (
  input  wire logic        clk_i,
  input  wire imc_ctl_t    ctl_i,
  input  wire logic [31:0] value_i,
  output logic      [15:0] root_o
);
  logic [31:0] v_q, res_q, bitv;
  logic [32:0] trial;
  logic [4:0]  sh;
  logic        ge;

  always_comb begin
    sh    = 5'd30 - {ctl_i.iter, 1'b0};
    bitv  = 32'd1 << sh;
    trial = {1'b0, res_q} + {1'b0, bitv};
    ge    = {1'b0, v_q} >= trial;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      v_q   <= value_i;
      res_q <= '0;
    end else if (ctl_i.step) begin
      if (ge) begin
        v_q   <= v_q - trial[31:0];
        res_q <= (res_q >> 1) + bitv;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

  assign root_o = res_q[15:0];
endmodule
`default_nettype wire

>>> sv/imc_cordic.sv
`default_nettype none
module imc_cordic import imc_pkg::*; (
  input  wire logic               clk_i,
  input  wire imc_ctl_t           ctl_i,
  input  wire logic signed [16:0] x_i,
  input  wire logic signed [16:0] y_i,
  output logic signed      [16:0] angle_o
);
  logic signed [33:0] x_q, y_q, xs, ys, xl, yl;
  logic signed [25:0] z_q, zr, q;
  logic               zero_q;

  always_comb begin
    xl = {{17{x_i[16]}}, x_i} <<< 14;
    yl = {{17{y_i[16]}}, y_i} <<< 14;
    xs = x_q >>> ctl_i.iter;
    ys = y_q >>> ctl_i.iter;
    zr = z_q + 26'sd128;
    q  = zr >>> 8;
    if (zero_q) begin
      angle_o = '0;
    end else if (q > ANGLE_LIMIT) begin
      angle_o = ANGLE_LIMIT[16:0];
    end else if (q < -ANGLE_LIMIT) begin
      angle_o = -ANGLE_LIMIT[16:0];
    end else begin
      angle_o = q[16:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      zero_q <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        x_q <= -xl;
        y_q <= -yl;
        z_q <= (y_i >= 0) ? HALF_TURN : -HALF_TURN;
      end else begin
        x_q <= xl;
        y_q <= yl;
        z_q <= '0;
      end
    end else if (ctl_i.step) begin
      if (y_q >= 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_tab(ctl_i.iter);
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_tab(ctl_i.iter);
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/imu_motion_classifier_unit.sv
// Sequence: a sample transaction steps through the squaring, load, root,
// rotation-load, rotation and finish states; a peak-reset one goes to finish.
// Both wait in finish until the output is free; a new one is taken only in idle.
// Work: six squarings on one multiplier, 16 root and 16 rotation steps, one bit per cycle.
// Reset: asynchronous, active low; control, config and result registers reset, input/sum ones do not.
`default_nettype none
module imu_motion_classifier_unit import imc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               command_i,
  input  wire logic signed [15:0] accel_x_i,
  input  wire logic signed [15:0] accel_y_i,
  input  wire logic signed [15:0] accel_z_i,
  input  wire logic signed [15:0] rate_x_i,
  input  wire logic signed [15:0] rate_y_i,
  input  wire logic signed [15:0] rate_z_i,
  input  wire logic        [31:0] now_ms_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed      [16:0] roll_angle_o,
  output logic signed      [16:0] pitch_angle_o,
  output logic             [15:0] accel_deviation_o,
  output logic             [15:0] gyro_magnitude_o,
  output logic             [15:0] peak_deviation_o,
  output logic             [1:0]  activity_o,
  output logic                    shake_held_o,
  input  wire logic               cfg_we_i,
  input  wire logic [IdxW-1:0]    cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);
  typedef enum logic [2:0] {ST_IDLE, ST_SQR, ST_LOAD, ST_ROOT, ST_PLOAD, ST_ROT, ST_FIN} state_e;

  state_e state_q;
  logic [3:0] cnt_q;
  logic out_valid_q;

  logic [15:0] still_acc_q, still_gyr_q, shake_acc_q, shake_gyr_q, hold_q;
  logic [3:0]  confirm_q;
  logic [8:0]  gain_q;

  logic cmd_q;
  logic signed [15:0] ax_q, ay_q, az_q, rx_q, ry_q, rz_q;
  logic [31:0] now_q;
  logic [31:0] syz_q, sa_q, sg_q;

  logic seen_q, seen_d, latch_q, latch_d;
  logic signed [16:0] roll_q, roll_d, pitch_q, pitch_d;
  logic [15:0] dev_q, dev_d, gyr_q, gyr_d, peak_q, peak_d;
  logic [31:0] start_q, start_d;
  logic [1:0]  act_q, act_d, pend_q, pend_d, cand;
  logic [3:0]  pcnt_q, pcnt_d;

  logic signed [15:0] mul_op;
  logic signed [31:0] sq;
  logic [15:0] h_root, a_root, g_root, dev;
  logic signed [16:0] roll_raw, pitch_raw;
  logic [31:0] elapsed;
  logic commit;
  imc_ctl_t root_ctl, rot_ctl;

  assign in_ready_o = (state_q == ST_IDLE);
  assign commit = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    unique case (cnt_q)
      4'd0:    mul_op = ay_q;
      4'd1:    mul_op = az_q;
      4'd2:    mul_op = ax_q;
      4'd3:    mul_op = rx_q;
      4'd4:    mul_op = ry_q;
      4'd5:    mul_op = rz_q;
      default: mul_op = ax_q;
    endcase
    sq = mul_op * mul_op;
  end

  assign root_ctl = '{load: state_q == ST_LOAD, step: state_q == ST_ROOT, iter: cnt_q};
  assign rot_ctl  = '{load: state_q == ST_PLOAD, step: state_q == ST_ROT, iter: cnt_q};

  imc_isqrt u_sqrt_h (.clk_i, .ctl_i(root_ctl), .value_i(syz_q), .root_o(h_root));
  imc_isqrt u_sqrt_a (.clk_i, .ctl_i(root_ctl), .value_i(sa_q), .root_o(a_root));
  imc_isqrt u_sqrt_g (.clk_i, .ctl_i(root_ctl), .value_i(sg_q), .root_o(g_root));

  imc_cordic u_roll (.clk_i, .ctl_i(rot_ctl), .x_i({az_q[15], az_q}),
                     .y_i({ay_q[15], ay_q}), .angle_o(roll_raw));
  imc_cordic u_pitch (.clk_i, .ctl_i(rot_ctl), .x_i({1'b0, h_root}),
                      .y_i(-{ax_q[15], ax_q}), .angle_o(pitch_raw));

  always_comb begin
    seen_d = seen_q; roll_d = roll_q; pitch_d = pitch_q;
    dev_d = dev_q; gyr_d = gyr_q; peak_d = peak_q;
    latch_d = latch_q; start_d = start_q;
    act_d = act_q; pend_d = pend_q; pcnt_d = pcnt_q;
    dev = (a_root >= ONE_G) ? a_root - ONE_G : ONE_G - a_root;
    elapsed = now_q - start_q;
    cand = ACT_MOVING;
    if (commit) begin
      if (cmd_q) begin
        peak_d = seen_q ? dev_q : '0;
      end else begin
        if (!seen_q) begin
          roll_d = roll_raw;
          pitch_d = pitch_raw;
        end else begin
          roll_d = lp_filter(roll_q, roll_raw, gain_q);
          pitch_d = lp_filter(pitch_q, pitch_raw, gain_q);
        end
        dev_d = dev;
        gyr_d = g_root;
        if (!seen_q || dev > peak_q) peak_d = dev;
        seen_d = 1'b1;
        if (latch_q && elapsed >= {16'd0, hold_q}) begin
          latch_d = 1'b0;
          pcnt_d = '0;
        end
        priority if (dev < still_acc_q && g_root < still_gyr_q) cand = ACT_STILL;
        else if (dev >= shake_acc_q || g_root >= shake_gyr_q) cand = ACT_SHAKE;
        else cand = ACT_MOVING;
        if (cand == ACT_SHAKE) begin
          if (!latch_d) begin
            latch_d = 1'b1;
            start_d = now_q;
          end
          act_d = ACT_SHAKE;
          pcnt_d = '0;
        end else if (!latch_d) begin
          if (cand == act_q) begin
            pcnt_d = '0;
          end else begin
            if (cand == pend_q) begin
              pcnt_d = pcnt_d + 4'd1;
            end else begin
              pend_d = cand;
              pcnt_d = 4'd1;
            end
            if (pcnt_d >= confirm_q) begin
              act_d = cand;
              pcnt_d = '0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= command_i;
      ax_q <= accel_x_i; ay_q <= accel_y_i; az_q <= accel_z_i;
      rx_q <= rate_x_i; ry_q <= rate_y_i; rz_q <= rate_z_i;
      now_q <= now_ms_i;
      syz_q <= '0; sa_q <= '0; sg_q <= '0;
    end else if (state_q == ST_SQR) begin
      if (cnt_q <= 4'd1) syz_q <= syz_q + sq;
      if (cnt_q <= 4'd2) sa_q <= sa_q + sq;
      else sg_q <= sg_q + sq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; cnt_q <= '0; out_valid_q <= 1'b0;
      still_acc_q <= 16'd328; still_gyr_q <= 16'd160;
      shake_acc_q <= 16'd1843; shake_gyr_q <= 16'd2880;
      confirm_q <= 4'd5; hold_q <= 16'd500; gain_q <= 9'd51;
      seen_q <= 1'b0; roll_q <= '0; pitch_q <= '0;
      dev_q <= '0; gyr_q <= '0; peak_q <= '0;
      latch_q <= 1'b0; start_q <= '0;
      act_q <= ACT_STILL; pend_q <= ACT_STILL; pcnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_STILL_ACCEL: still_acc_q <= cfg_data_i;
          REG_STILL_GYRO:  still_gyr_q <= cfg_data_i;
          REG_SHAKE_ACCEL: shake_acc_q <= cfg_data_i;
          REG_SHAKE_GYRO:  shake_gyr_q <= cfg_data_i;
          REG_CONFIRM:     confirm_q <= cfg_data_i[3:0];
          REG_HOLD_MS:     hold_q <= cfg_data_i;
          REG_GAIN:        gain_q <= cfg_data_i[8:0];
          default: ;
        endcase
      end
      seen_q <= seen_d; roll_q <= roll_d; pitch_q <= pitch_d;
      dev_q <= dev_d; gyr_q <= gyr_d; peak_q <= peak_d;
      latch_q <= latch_d; start_q <= start_d;
      act_q <= act_d; pend_q <= pend_d; pcnt_q <= pcnt_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (in_valid_i) state_q <= command_i ? ST_FIN : ST_SQR;
        end
        ST_SQR: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd5) state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          cnt_q <= '0;
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) state_q <= ST_PLOAD;
        end
        ST_PLOAD: begin
          cnt_q <= '0;
          state_q <= ST_ROT;
        end
        ST_ROT: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (commit) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign roll_angle_o = roll_q;
  assign pitch_angle_o = pitch_q;
  assign accel_deviation_o = dev_q;
  assign gyro_magnitude_o = gyr_q;
  assign peak_deviation_o = peak_q;
  assign activity_o = act_q;
  assign shake_held_o = latch_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != ST_IDLE)
    else $error("accept did not start work");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(peak_deviation_o)
      && $stable(activity_o))
    else $error("pending result changed");
  a_activity_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q <= ACT_SHAKE)
    else $error("illegal activity");
  a_shake_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(latch_q) |-> act_q == ACT_SHAKE)
    else $error("latch without shake");
endmodule
`default_nettype wire
